// File: design/hkv_pkg.sv
// hkv_pkg: sizes, status codes and the front-to-back event type of the kv store
// depends on nothing; imported by every module of the block
`default_nettype none
package hkv_pkg;

	// store geometry
	localparam int ENTRIES     = 1024;
	localparam int KEY_BYTES   = 32;
	localparam int VALUE_BYTES = 64;

	localparam int SLOT_W = $clog2(ENTRIES);
	localparam int KCNT_W = $clog2(KEY_BYTES + 1);
	localparam int VCNT_W = $clog2(VALUE_BYTES + 1);
	localparam int KIDX_W = $clog2(KEY_BYTES);
	localparam int VIDX_W = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;

	// hash
	localparam logic [31:0] HASH_MUL = 32'd131;
	localparam int HASH_W = 31;

	// event queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// result status codes
	localparam logic [1:0] ST_INS  = 2'd0;
	localparam logic [1:0] ST_VAL  = 2'd1;
	localparam logic [1:0] ST_NF   = 2'd2;
	localparam logic [1:0] ST_LONG = 2'd3;

	// one classified input item
	typedef struct packed {
		logic              wr_key;
		logic [KIDX_W-1:0] kidx;
		logic              wr_val;
		logic [VIDX_W-1:0] vidx;
		logic [7:0]        data;
		logic              fin;
		logic              action;
		logic              ovf;
		logic [HASH_W-1:0] hash;
		logic [KCNT_W-1:0] kcnt;
		logic [VCNT_W-1:0] vcnt;
	} evt_t;

endpackage
`default_nettype wire

// File: design/hkv_front.sv
// hkv_front: accepts items, runs the hash and byte counts, classifies each item
// depends on hkv_pkg
`default_nettype none
module hkv_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        action,
	input  wire logic        part,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	input  wire logic        q_full,
	output logic             q_push,
	output hkv_pkg::evt_t    q_data
);
	import hkv_pkg::*;

	logic [31:0]       hash_q, hash_n;
	logic [KCNT_W-1:0] kcnt_q, kcnt_n;
	logic [VCNT_W-1:0] vcnt_q, vcnt_n;
	logic              kend_q, kend_n, vend_q, vend_n, ovf_q, ovf_n;
	logic              acc;

	assign acc    = push && !q_full;
	assign q_push = acc;

	// classify the item and work out the next request state
	always_comb begin
		hash_n = hash_q;
		kcnt_n = kcnt_q;
		vcnt_n = vcnt_q;
		kend_n = kend_q;
		vend_n = vend_q;
		ovf_n  = ovf_q;
		q_data = '0;
		if (!part) begin
			if (!kend_q) begin
				if (data_byte == 8'd0) begin
					kend_n = 1'b1;
				end else begin
					hash_n = hash_q * HASH_MUL + {24'd0, data_byte};
					if (kcnt_q < KCNT_W'(KEY_BYTES)) begin
						q_data.wr_key = 1'b1;
						q_data.kidx   = kcnt_q[KIDX_W-1:0];
						kcnt_n        = kcnt_q + 1'b1;
					end else begin
						ovf_n = 1'b1;
					end
				end
			end
		end else begin
			if (!vend_q) begin
				if (data_byte == 8'd0) begin
					vend_n = 1'b1;
				end else if (vcnt_q < VCNT_W'(VALUE_BYTES)) begin
					q_data.wr_val = 1'b1;
					q_data.vidx   = vcnt_q[VIDX_W-1:0];
					vcnt_n        = vcnt_q + 1'b1;
				end
			end
		end
		q_data.data   = data_byte;
		q_data.fin    = last;
		q_data.action = action;
		q_data.ovf    = ovf_n;
		q_data.hash   = hash_n[HASH_W-1:0];
		q_data.kcnt   = kcnt_n;
		q_data.vcnt   = vcnt_n;
	end

	// request state, cleared after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			kcnt_q <= '0;
			vcnt_q <= '0;
			kend_q <= 1'b0;
			vend_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (acc) begin
			if (last) begin
				hash_q <= '0;
				kcnt_q <= '0;
				vcnt_q <= '0;
				kend_q <= 1'b0;
				vend_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				hash_q <= hash_n;
				kcnt_q <= kcnt_n;
				vcnt_q <= vcnt_n;
				kend_q <= kend_n;
				vend_q <= vend_n;
				ovf_q  <= ovf_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/hkv_queue.sv
// hkv_queue: short event queue between front and back
// depends on hkv_pkg
`default_nettype none
module hkv_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  hkv_pkg::evt_t    din,
	output logic             full,
	input  wire logic        pop,
	output hkv_pkg::evt_t    dout,
	output logic             empty
);
	import hkv_pkg::*;

	evt_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

// File: design/hkv_back.sv
// hkv_back: request buffers, slot reduction, store memories and result register
// depends on hkv_pkg
`default_nettype none
module hkv_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  hkv_pkg::evt_t    q_data,
	output logic             q_pop,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       status,
	output logic [7:0]       value_byte,
	output logic             last_result
);
	import hkv_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;
	localparam logic [2:0] S_RES  = 3'd6;

	logic [2:0] state_q, state_n;

	// store memories, one row per slot
	logic [KEY_BYTES-1:0][7:0]   key_mem [ENTRIES];
	logic [VALUE_BYTES-1:0][7:0] val_mem [ENTRIES];
	logic [KEY_BYTES-1:0][7:0]   krow_q;
	logic [VALUE_BYTES-1:0][7:0] vrow_q;

	logic [7:0] kbuf_q [KEY_BYTES];
	logic [7:0] vbuf_q [VALUE_BYTES];
	logic [KEY_BYTES-1:0][7:0]   kpad;
	logic [VALUE_BYTES-1:0][7:0] vpad;

	logic [KCNT_W-1:0] kcnt_q;
	logic [VCNT_W-1:0] vcnt_q;
	logic              act_q;
	logic [HASH_W-1:0] hash_q;
	logic [SLOT_W-1:0] slot_q, clr_q;
	logic [VIDX_W-1:0] vidx_q;
	logic [1:0]        res_st_q;

	logic              we;
	logic [SLOT_W-1:0] waddr;
	logic              out_v_q, out_free, emit;
	logic [1:0]        st_n;
	logic [7:0]        vb_n;
	logic              lr_n;
	logic [7:0]        nxt_byte;

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_v_q || pop;
	assign empty    = !out_v_q;

	// zero-padded rows from the request buffers
	always_comb begin
		for (int i = 0; i < KEY_BYTES; i++) begin
			kpad[i] = (KCNT_W'(i) < kcnt_q) ? kbuf_q[i] : 8'd0;
		end
		for (int i = 0; i < VALUE_BYTES; i++) begin
			vpad[i] = (VCNT_W'(i) < vcnt_q) ? vbuf_q[i] : 8'd0;
		end
	end

	// byte after the current value byte
	always_comb begin
		if (vidx_q == VIDX_W'(VALUE_BYTES - 1)) begin
			nxt_byte = 8'd0;
		end else begin
			nxt_byte = vrow_q[vidx_q + 1'b1];
		end
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		we      = 1'b0;
		waddr   = slot_q;
		emit    = 1'b0;
		st_n    = res_st_q;
		vb_n    = 8'd0;
		lr_n    = 1'b1;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == SLOT_W'(ENTRIES - 1)) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_empty && q_data.fin) begin
					state_n = q_data.ovf ? S_RES : S_ACC;
				end
			end
			S_ACC: begin
				if (!act_q) begin
					we      = 1'b1;
					state_n = S_RES;
				end else begin
					state_n = S_CMP;
				end
			end
			S_CMP: begin
				state_n = ((krow_q == kpad) && (vrow_q[0] != 8'd0)) ? S_EMIT : S_RES;
			end
			S_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					st_n    = ST_VAL;
					vb_n    = vrow_q[vidx_q];
					lr_n    = (nxt_byte == 8'd0);
					if (lr_n) begin
						state_n = S_IDLE;
					end
				end
			end
			S_RES: begin
				if (out_free) begin
					emit    = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= (state_q == S_CLR) ? '0 : kpad;
			val_mem[waddr] <= (state_q == S_CLR) ? '0 : vpad;
		end
		krow_q <= key_mem[slot_q];
		vrow_q <= val_mem[slot_q];
	end

	// request buffers and per-request payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_data.wr_key) begin
				kbuf_q[q_data.kidx] <= q_data.data;
			end
			if (q_data.wr_val) begin
				vbuf_q[q_data.vidx] <= q_data.data;
			end
			if (q_data.fin) begin
				kcnt_q <= q_data.kcnt;
				vcnt_q <= q_data.vcnt;
				act_q  <= q_data.action;
				hash_q <= q_data.hash;
			end
		end
		if (state_q == S_CMP) begin
			vidx_q <= '0;
		end else if (emit) begin
			vidx_q <= vidx_q + 1'b1;
		end
		if (emit) begin
			status      <= st_n;
			value_byte  <= vb_n;
			last_result <= lr_n;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			slot_q   <= '0;
			res_st_q <= ST_NF;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			// slot count is a power of two, so the reduction is the low hash bits
			if (q_pop && q_data.fin) begin
				slot_q   <= SLOT_W'(q_data.hash % ENTRIES);
				res_st_q <= q_data.ovf ? ST_LONG : (q_data.action ? ST_NF : ST_INS);
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/hashed_direct_mapped_kv_store.sv
// hashed_direct_mapped_kv_store: top level, front, event queue and back
// depends on hkv_pkg, hkv_front, hkv_queue, hkv_back
//
//  channel   handshake        fields
//  request   push / full      action, part, data_byte, last
//  result    pop / empty      status, value_byte, last_result
//
// a byte item is taken every cycle while the event queue has room
// the slot is the low hash bits, taken as the last item leaves the queue; the back
// then writes the slot row on an insert, compares the stored key on a find, emits one
// result per value byte on a find that hits, and skips the store on a key-too-long request
// after reset the back clears one slot row per cycle until every slot row is cleared;
// items are queued but not processed until that pass ends
// a stalled result holds in the output register while the back waits
`default_nettype none
module hashed_direct_mapped_kv_store (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic       action,
	input  wire logic       part,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      status,
	output logic [7:0]      value_byte,
	output logic            last_result
);
	import hkv_pkg::*;

	evt_t f_evt, b_evt;
	logic f_push, q_full, q_empty, b_pop;

	assign full = q_full;

	// item classification
	hkv_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .action(action), .part(part),
		.data_byte(data_byte), .last(last), .q_full(q_full),
		.q_push(f_push), .q_data(f_evt)
	);

	// decoupling queue
	hkv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_push), .din(f_evt), .full(q_full),
		.pop(b_pop), .dout(b_evt), .empty(q_empty)
	);

	// store access and results
	hkv_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(b_evt), .q_pop(b_pop),
		.empty(empty), .pop(pop), .status(status), .value_byte(value_byte),
		.last_result(last_result)
	);

endmodule
`default_nettype wire

// File: design/hkv_checker.sv
// hkv_checker: port-level checks of the result channel, bound to the top level
// depends on hkv_pkg and hashed_direct_mapped_kv_store ports only
`default_nettype none
module hkv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [1:0] status,
	input wire logic [7:0] value_byte,
	input wire logic       last_result
);
	import hkv_pkg::*;

	// a found value byte is never the terminating zero
	a_val_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_VAL) |-> (value_byte != 8'd0))
		else $error("value result carries a zero byte");

	// other results carry a zero byte
	a_other_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_VAL) |-> (value_byte == 8'd0))
		else $error("non-value result carries a byte");

	// ack, not-found and key-too-long each end their request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_VAL) |-> last_result)
		else $error("single result not marked last");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(value_byte)))
		else $error("stalled result changed");

endmodule

bind hashed_direct_mapped_kv_store hkv_checker u_hkv_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .status(status),
	.value_byte(value_byte), .last_result(last_result)
);
`default_nettype wire

// File: tb/sv/tb_hashed_direct_mapped_kv_store.sv
// tb_hashed_direct_mapped_kv_store: self-checking bench for the hashed kv store
// depends on hkv_pkg and hashed_direct_mapped_kv_store; predicts results per item
`default_nettype none
module tb_hashed_direct_mapped_kv_store;
	import hkv_pkg::*;

	// one expected or observed result item
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] value_byte;
		logic       last_result;
	} kv_result_t;

	// mirror of the store plus the request being collected
	class kv_scoreboard;
		logic [7:0] keys[ENTRIES][KEY_BYTES];
		logic [7:0] vals[ENTRIES][VALUE_BYTES];
		logic [31:0] hash;
		logic [7:0] kbuf[KEY_BYTES];
		logic [7:0] vbuf[VALUE_BYTES];
		int kcnt, vcnt;
		bit ovf, kend, vend;
		kv_result_t pending[$];
		int errors;

		function void clear_request();
			hash = 0; kcnt = 0; vcnt = 0; ovf = 0; kend = 0; vend = 0;
		endfunction

		function void reset_store();
			foreach (keys[s, i]) keys[s][i] = 0;
			foreach (vals[s, i]) vals[s][i] = 0;
			clear_request();
			errors = 0;
		endfunction

		function void push_result(logic [1:0] st, logic [7:0] vb, logic lr);
			kv_result_t r;
			r.status = st; r.value_byte = vb; r.last_result = lr;
			pending.push_back(r);
		endfunction

		// note one accepted input item
		function void note_item(logic act, logic prt, logic [7:0] b, logic lst);
			int slot, n;
			bit match;
			logic [7:0] want;
			if (prt == 1'b0) begin
				if (!kend) begin
					if (b == 0) kend = 1;
					else begin
						hash = hash * HASH_MUL + {24'd0, b};
						if (kcnt < KEY_BYTES) begin
							kbuf[kcnt] = b; kcnt++;
						end else ovf = 1;
					end
				end
			end else if (!vend) begin
				if (b == 0) vend = 1;
				else if (vcnt < VALUE_BYTES) begin
					vbuf[vcnt] = b; vcnt++;
				end
			end
			if (!lst) return;
			if (ovf) push_result(ST_LONG, 0, 1);
			else begin
				slot = (hash & 32'h7FFF_FFFF) % ENTRIES;
				if (act == 1'b0) begin
					for (int i = 0; i < KEY_BYTES; i++)
						keys[slot][i] = (i < kcnt) ? kbuf[i] : 8'd0;
					for (int i = 0; i < VALUE_BYTES; i++)
						vals[slot][i] = (i < vcnt) ? vbuf[i] : 8'd0;
					push_result(ST_INS, 0, 1);
				end else begin
					match = 1; n = 0;
					for (int i = 0; i < KEY_BYTES; i++) begin
						want = (i < kcnt) ? kbuf[i] : 8'd0;
						if (keys[slot][i] != want) match = 0;
					end
					if (match)
						for (int i = 0; i < VALUE_BYTES; i++) begin
							if (vals[slot][i] == 0) break;
							push_result(ST_VAL, vals[slot][i], 0);
							n++;
						end
					if (n == 0) push_result(ST_NF, 0, 1);
					else pending[$].last_result = 1;
				end
			end
			clear_request();
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(kv_result_t got);
			kv_result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0, action = 0, part = 0, last = 0, pop = 0;
	logic [7:0] data_byte = 0;
	logic full, empty, last_result;
	logic [1:0] status;
	logic [7:0] value_byte;
	int send_idle, recv_idle;
	longint cycles;
	kv_scoreboard sb;
	logic [7:0] key_pool[8][$];

	hashed_direct_mapped_kv_store uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.part(part), .data_byte(data_byte), .last(last), .empty(empty), .pop(pop),
		.status(status), .value_byte(value_byte), .last_result(last_result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stall, check at each accepting edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result({status, value_byte, last_result});
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 64'd3_000_000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// send one item, with random idle cycles first; push stays high until the next call
	task automatic send_item(logic act, logic prt, logic [7:0] b, logic lst);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1; action <= act; part <= prt; data_byte <= b; last <= lst;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_item(act, prt, b, lst);
	endtask

	// whole request: key bytes, then any value bytes
	task automatic send_request(logic act, logic [7:0] key[$], logic [7:0] val[$]);
		int total;
		total = key.size() + val.size();
		if (total == 0) begin
			send_item(act, 1'b0, 8'd0, 1'b1);
			return;
		end
		foreach (key[i]) send_item(act, 1'b0, key[i], (i == total - 1));
		foreach (val[i]) send_item(act, 1'b1, val[i], (key.size() + i == total - 1));
	endtask

	function automatic void rand_bytes(ref logic [7:0] q[$], input int n);
		q.delete();
		for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255, 1)));
	endfunction

	task automatic random_phase(int n);
		logic [7:0] k[$], v[$];
		int sel, kl;
		for (int r = 0; r < n; r++) begin
			sel = $urandom_range(99);
			if (sel < 85) begin
				// well-formed insert or find, mostly on a small pool of keys
				k = key_pool[$urandom_range(7)];
				if ($urandom_range(9) == 0) begin
					kl = ($urandom_range(3) == 0) ? $urandom_range(KEY_BYTES + 3, 1)
					                              : $urandom_range(6, 1);
					rand_bytes(k, kl);
				end
				if ($urandom_range(1) == 0) begin
					rand_bytes(v, ($urandom_range(9) == 0) ? $urandom_range(VALUE_BYTES + 2)
					                                       : $urandom_range(5));
					send_request(1'b0, k, v);
				end else begin
					v.delete();
					send_request(1'b1, k, v);
				end
			end else begin
				// noise: random fields, zeros, mixed order
				kl = $urandom_range(6, 1);
				for (int i = 0; i < kl; i++)
					send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
						($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255)),
						(i == kl - 1));
			end
		end
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		logic [7:0] k[$], v[$];
		sb = new();
		sb.reset_store();
		cycles = 0;
		send_idle = 0; recv_idle = 0;
		for (int i = 0; i < 8; i++) rand_bytes(key_pool[i], $urandom_range(4, 1));
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, both kinds, zero terminators, overflow, empty key
		k = '{8'hFF, 8'h01}; v = '{8'hFF, 8'h01, 8'h80};
		send_request(1'b0, k, v);
		send_request(1'b1, k, v);
		k = '{8'h7F}; v.delete();
		send_request(1'b1, k, v);
		send_request(1'b0, k, v);
		send_request(1'b1, k, v);
		send_item(1'b0, 1'b1, 8'h55, 1'b0);
		send_item(1'b1, 1'b0, 8'd0, 1'b1);
		send_item(1'b1, 1'b0, 8'd0, 1'b1);
		send_item(1'b0, 1'b0, 8'h42, 1'b0);
		send_item(1'b0, 1'b1, 8'h33, 1'b0);
		send_item(1'b0, 1'b1, 8'd0, 1'b0);
		send_item(1'b0, 1'b1, 8'h44, 1'b0);
		send_item(1'b0, 1'b0, 8'h43, 1'b1);
		k = '{8'h42, 8'h43}; send_request(1'b1, k, v);
		send_item(1'b1, 1'b0, 8'h42, 1'b0);
		send_item(1'b1, 1'b0, 8'd0, 1'b0);
		send_item(1'b1, 1'b0, 8'h43, 1'b1);
		rand_bytes(k, KEY_BYTES + 1); send_request(1'b0, k, v);
		rand_bytes(k, KEY_BYTES); rand_bytes(v, VALUE_BYTES + 1);
		send_request(1'b0, k, v);
		v.delete(); send_request(1'b1, k, v);

		send_idle = 11; recv_idle = 70;
		random_phase(12);
		send_idle = 70; recv_idle = 11;
		random_phase(12);
		send_idle = 0; recv_idle = 0;
		random_phase(12);
		push <= 0;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
design/hkv_pkg.sv
design/hkv_front.sv
design/hkv_queue.sv
design/hkv_back.sv
design/hashed_direct_mapped_kv_store.sv
design/hkv_checker.sv
tb/sv/tb_hashed_direct_mapped_kv_store.sv
